FILE: rtl/core/pfe_pkg.sv
// Shared types and constants for the protobuf field encoder.
// No dependencies; imported by pfe_varint_unit, protobuf_field_encoder and pfe_checker.
package pfe_pkg;

	localparam int VAL_W  = 64;
	localparam int GRP_W  = 7;
	localparam int FLD_W  = 29;
	localparam int TOT_W  = 32;

	// Item kinds
	localparam logic [1:0] KIND_VARINT_FIELD = 2'd0;
	localparam logic [1:0] KIND_LEN_HDR      = 2'd1;
	localparam logic [1:0] KIND_BARE_VARINT  = 2'd2;
	localparam logic [1:0] KIND_RAW_BYTE     = 2'd3;

	// Wire types placed in the low bits of a tag
	localparam logic [2:0] WIRE_VARINT    = 3'd0;
	localparam logic [2:0] WIRE_LEN_DELIM = 3'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TAG,
		ST_VAL,
		ST_RAW
	} state_t;

	// Sequencer to shift unit
	typedef struct packed {
		logic             load;
		logic             step;
		logic [VAL_W-1:0] value;
	} vu_ctrl_t;

	// Shift unit to sequencer
	typedef struct packed {
		logic       is_last;
		logic [7:0] grp_byte;
		logic [7:0] raw_byte;
	} vu_stat_t;

endpackage

FILE: rtl/core/pfe_varint_unit.sv
// Shared varint shift unit: holds the value being encoded and peels off
// one 7-bit group per step. Depends on pfe_pkg.
module pfe_varint_unit
	import pfe_pkg::*;
(
	input  logic     clk,
	input  vu_ctrl_t ctrl,
	output vu_stat_t stat
);

	logic [VAL_W-1:0] value_q;

	// Load a new value or drop the group just sent
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			value_q <= ctrl.value;
		end else if (ctrl.step) begin
			value_q <= value_q >> GRP_W;
		end
	end

	// Current group with continuation bit unless nothing remains above it
	always_comb begin
		stat.is_last  = (value_q[VAL_W-1:GRP_W] == '0);
		stat.grp_byte = {~stat.is_last, value_q[GRP_W-1:0]};
		stat.raw_byte = value_q[7:0];
	end

endmodule

FILE: rtl/core/protobuf_field_encoder.sv
// Protobuf wire-item encoder, top level.
// Depends on pfe_pkg and pfe_varint_unit.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one request: kind, field_number
//   and payload. Kind 0 and 1 send a tag varint then the payload varint,
//   kind 2 sends the payload varint alone, kind 3 sends payload[7:0].
//   Output channel (out_valid/out_ready) gives one byte per transfer, with
//   last on the final byte of an item, deliver = !counting_only and
//   running_total = bytes sent so far including this one (wraps at 2^32).
//   cfg_we/cfg_data write counting_only; write it only while idle.
// Timing:
//   One byte leaves the shared shift unit per cycle unless the output
//   register stalls; an item of N bytes (1 to 15) is accepted, then each
//   byte is sent from the loaded shift unit via the output register. in_ready
//   is high only while the sequencer is idle; the next item may be taken
//   while the last byte still waits in the output register.
// Reset: arst_n clears the sequencer, the byte counter, counting_only and
//   out_valid. A stalled receiver holds the output register and the
//   sequencer simply waits; no byte is lost or repeated.
module protobuf_field_encoder
	import pfe_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       kind,
	input  logic [FLD_W-1:0] field_number,
	input  logic [VAL_W-1:0] payload,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             last,
	output logic             deliver,
	output logic [TOT_W-1:0] running_total
);

	state_t           state_q, state_d;
	logic             counting_only_q;
	logic [VAL_W-1:0] payload_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             last_q;
	logic             deliver_q;
	logic [TOT_W-1:0] total_q;

	logic       accept;
	logic       emit;
	logic [7:0] emit_byte;
	logic       emit_last;
	vu_ctrl_t   vu_ctrl;
	vu_stat_t   vu_stat;

	pfe_varint_unit u_varint (
		.clk  (clk),
		.ctrl (vu_ctrl),
		.stat (vu_stat)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid & in_ready;
	assign emit     = (state_q != ST_IDLE) & (~out_valid_q | out_ready);

	// Sequencer: next state, shift unit control and byte selection
	always_comb begin
		state_d       = state_q;
		vu_ctrl.load  = 1'b0;
		vu_ctrl.step  = 1'b0;
		vu_ctrl.value = payload;
		emit_byte     = vu_stat.grp_byte;
		emit_last     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					vu_ctrl.load = 1'b1;
					case (kind)
						KIND_VARINT_FIELD: begin
							vu_ctrl.value = {{(VAL_W-FLD_W-3){1'b0}}, field_number, WIRE_VARINT};
							state_d       = ST_TAG;
						end
						KIND_LEN_HDR: begin
							vu_ctrl.value = {{(VAL_W-FLD_W-3){1'b0}}, field_number,
								WIRE_LEN_DELIM};
							state_d       = ST_TAG;
						end
						KIND_BARE_VARINT: state_d = ST_VAL;
						default:          state_d = ST_RAW;
					endcase
				end
			end
			ST_TAG: begin
				if (emit) begin
					if (vu_stat.is_last) begin
						vu_ctrl.load  = 1'b1;
						vu_ctrl.value = payload_q;
						state_d       = ST_VAL;
					end else begin
						vu_ctrl.step = 1'b1;
					end
				end
			end
			ST_VAL: begin
				emit_last = vu_stat.is_last;
				if (emit) begin
					if (vu_stat.is_last) begin
						state_d = ST_IDLE;
					end else begin
						vu_ctrl.step = 1'b1;
					end
				end
			end
			ST_RAW: begin
				emit_byte = vu_stat.raw_byte;
				emit_last = 1'b1;
				if (emit) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold sequencer state, counter, mode and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			counting_only_q <= 1'b0;
			out_valid_q     <= 1'b0;
			total_q         <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				counting_only_q <= cfg_data;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				total_q     <= total_q + 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload and held item value
	always_ff @(posedge clk) begin
		if (accept) begin
			payload_q <= payload;
		end
		if (emit) begin
			out_byte_q <= emit_byte;
			last_q     <= emit_last;
			deliver_q  <= ~counting_only_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign last          = last_q;
	assign deliver       = deliver_q;
	assign running_total = total_q;

endmodule

FILE: rtl/core/pfe_checker.sv
// Port-level checks for protobuf_field_encoder, attached by bind.
// Depends on pfe_pkg.
module pfe_checker
	import pfe_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [7:0]       out_byte,
	input logic             last,
	input logic [TOT_W-1:0] running_total
);

	// A stalled byte holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
		else $error("output byte changed while stalled");

	// No new request while an item still has bytes to send
	a_busy_mid_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("input ready in the middle of an item");

	// Each following byte counts one more
	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=>
			!out_valid || (running_total == $past(running_total) + 32'd1))
		else $error("running total did not advance by one");

endmodule

bind protobuf_field_encoder pfe_checker u_pfe_checker (.*);
